### hw/rtl/glt_pkg.sv
// shared types and constants for the golay L thinning pass
// job record between front and back, queue status, mask tables, register indexes
// no dependencies
package glt_pkg;

    localparam int PIX_W     = 8;
    localparam int COORD_W   = 10;
    localparam int COUNT_W   = 20;
    localparam int CFG_W     = 11;
    localparam int MASK_W    = 3;
    localparam int CFG_IDX_W = 2;
    localparam int RES_N     = 3;

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;
    localparam int Q_CNT_W = 3;

    localparam logic [PIX_W-1:0]   RIDGE_LIMIT = 8'd128;
    localparam logic [PIX_W-1:0]   CLEARED     = 8'd255;
    localparam logic [COUNT_W-1:0] COUNT_MAX   = '1;
    localparam logic [CFG_W-1:0]   SIZE_RESET  = 11'd1024;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    localparam cfg_idx_t CFG_IMAGE_WIDTH  = 2'd0;
    localparam cfg_idx_t CFG_IMAGE_HEIGHT = 2'd1;
    localparam cfg_idx_t CFG_MASK_SELECT  = 2'd2;

    // result slots of one job, in emission order
    localparam int RES_CENTRE = 0;   // pixel left-above the input
    localparam int RES_RIGHT  = 1;   // pixel above the input at row end
    localparam int RES_BELOW  = 2;   // the input itself on the last row

    typedef struct packed {
        logic [RES_N-1:0]   present;
        logic               removed;
        logic [PIX_W-1:0]   pix_centre;
        logic [PIX_W-1:0]   pix_right;
        logic [PIX_W-1:0]   pix_new;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic [COUNT_W-1:0] count;
        logic               frame_end;
    } glt_job_t;

    typedef struct packed {
        logic [Q_CNT_W-1:0] count;
        logic               head_valid;
    } glt_q_status_t;

    // bit 3*row+col of the 3x3 window, row 0 on top
    function automatic logic [8:0] care_bits(input logic [MASK_W-1:0] sel);
        logic [8:0] b;
        case (sel)
            3'd0:    b = 9'h1D7;
            3'd1:    b = 9'h0BE;
            3'd2:    b = 9'h17D;
            3'd3:    b = 9'h1BA;
            3'd4:    b = 9'h1D7;
            3'd5:    b = 9'h0FA;
            3'd6:    b = 9'h17D;
            3'd7:    b = 9'h0BB;
            default: b = 9'h1D7;
        endcase
        return b;
    endfunction

    function automatic logic [8:0] want_bits(input logic [MASK_W-1:0] sel);
        logic [8:0] b;
        case (sel)
            3'd0:    b = 9'h1D0;
            3'd1:    b = 9'h098;
            3'd2:    b = 9'h059;
            3'd3:    b = 9'h01A;
            3'd4:    b = 9'h017;
            3'd5:    b = 9'h032;
            3'd6:    b = 9'h134;
            3'd7:    b = 9'h0B0;
            default: b = 9'h1D0;
        endcase
        return b;
    endfunction

endpackage

### hw/rtl/glt_front.sv
// front end: accepts pixels, tracks position, keeps the two line stores and
// the window, decides removals and pushes one job per pixel that has result words into the queue
// depends on glt_pkg
module glt_front import glt_pkg::*; #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [PIX_W-1:0] s_pixel_in,
    input  logic [CFG_W-1:0] image_width,
    input  logic [CFG_W-1:0] image_height,
    input  logic [MASK_W-1:0] mask_select,
    input  glt_q_status_t    q_status,
    output logic             push,
    output glt_job_t         push_job
);

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int RW  = $clog2(MAX_HEIGHT);
    localparam int MW0 = ($clog2(MAX_WIDTH + 1) > CFG_W) ? $clog2(MAX_WIDTH + 1) : CFG_W;
    localparam int MW1 = ($clog2(MAX_HEIGHT + 1) > MW0) ? $clog2(MAX_HEIGHT + 1) : MW0;
    localparam int DW  = MW1 + 1;
    localparam logic [DW-1:0] MAXW_C = DW'(MAX_WIDTH);
    localparam logic [DW-1:0] MAXH_C = DW'(MAX_HEIGHT);
    localparam logic [DW-1:0] MIN_SZ = DW'(3);

    // position counters
    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;

    // stage after the line store read
    logic             s1_valid_reg;
    logic [PIX_W-1:0] s1_pix_reg;
    logic [CW-1:0]    s1_col_reg;
    logic [RW-1:0]    s1_row_reg;
    logic [RES_N-1:0] s1_has_reg;
    logic             s1_interior_reg;
    logic             s1_frame_end_reg;

    // line stores share one address, entry is {upper, middle}
    logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
    logic [2*PIX_W-1:0] mem_q_reg;

    // window columns 0, 1 and 2, rows top to bottom
    logic [PIX_W-1:0] wcol1_reg [3];
    logic [PIX_W-1:0] wcol2_reg [3];
    logic [PIX_W-1:0] new_col [3];

    logic [COUNT_W-1:0] cnt_reg, cnt_after;

    logic [DW-1:0] w_eff, h_eff, c_ext, r_ext;
    logic          last_col, last_row, accept;
    logic [RES_N-1:0] has;
    logic          interior;
    logic [8:0]    ridge_bits;
    logic          removing;

    always_comb begin
        if (DW'(image_width) < MIN_SZ) begin
            w_eff = MIN_SZ;
        end else if (DW'(image_width) > MAXW_C) begin
            w_eff = MAXW_C;
        end else begin
            w_eff = DW'(image_width);
        end
        if (DW'(image_height) < MIN_SZ) begin
            h_eff = MIN_SZ;
        end else if (DW'(image_height) > MAXH_C) begin
            h_eff = MAXH_C;
        end else begin
            h_eff = DW'(image_height);
        end
    end

    assign c_ext    = DW'(col_reg);
    assign r_ext    = DW'(row_reg);
    assign last_col = c_ext >= (w_eff - DW'(1));
    assign last_row = r_ext >= (h_eff - DW'(1));

    // credit against the queue: one pixel may sit in the stage after the read
    assign s_ready = (q_status.count + Q_CNT_W'(s1_valid_reg)) < Q_CNT_W'(Q_DEPTH);
    assign accept  = s_valid && s_ready;

    always_comb begin
        has[RES_CENTRE] = (r_ext >= DW'(1)) && (c_ext >= DW'(1));
        has[RES_RIGHT]  = (r_ext >= DW'(1)) && last_col;
        has[RES_BELOW]  = last_row;
        interior = (r_ext >= DW'(2)) && (c_ext >= DW'(2))
                && (r_ext - DW'(1) <= h_eff - DW'(2))
                && (c_ext - DW'(1) <= w_eff - DW'(2));
    end

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept) begin
            if (last_col && last_row) begin
                col_next = '0;
                row_next = '0;
            end else if (last_col) begin
                col_next = '0;
                row_next = row_reg + RW'(1);
            end else begin
                col_next = col_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end else begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_pix_reg       <= s_pixel_in;
            s1_col_reg       <= col_reg;
            s1_row_reg       <= row_reg;
            s1_has_reg       <= has;
            s1_interior_reg  <= interior;
            s1_frame_end_reg <= last_col && last_row;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            mem_q_reg <= line_mem[col_reg];
        end
        if (s1_valid_reg) begin
            line_mem[s1_col_reg] <= {mem_q_reg[PIX_W-1:0], s1_pix_reg};
        end
    end

    always_comb begin
        new_col[0] = mem_q_reg[2*PIX_W-1:PIX_W];
        new_col[1] = mem_q_reg[PIX_W-1:0];
        new_col[2] = s1_pix_reg;
        for (int i = 0; i < 3; i++) begin
            ridge_bits[3*i]     = wcol1_reg[i] < RIDGE_LIMIT;
            ridge_bits[3*i + 1] = wcol2_reg[i] < RIDGE_LIMIT;
            ridge_bits[3*i + 2] = new_col[i] < RIDGE_LIMIT;
        end
        removing = s1_interior_reg
                && ((ridge_bits & care_bits(mask_select)) == want_bits(mask_select));
        cnt_after = (removing && cnt_reg != COUNT_MAX) ? cnt_reg + COUNT_W'(1) : cnt_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            for (int i = 0; i < 3; i++) begin
                wcol1_reg[i] <= '0;
                wcol2_reg[i] <= '0;
            end
        end else if (s1_valid_reg) begin
            cnt_reg <= s1_frame_end_reg ? '0 : cnt_after;
            for (int i = 0; i < 3; i++) begin
                wcol1_reg[i] <= wcol2_reg[i];
                wcol2_reg[i] <= new_col[i];
            end
        end
    end

    always_comb begin
        push                = s1_valid_reg && (s1_has_reg != '0);
        push_job.present    = s1_has_reg;
        push_job.removed    = removing;
        push_job.pix_centre = removing ? CLEARED : wcol2_reg[1];
        push_job.pix_right  = new_col[1];
        push_job.pix_new    = s1_pix_reg;
        push_job.col        = COORD_W'(s1_col_reg);
        push_job.row        = COORD_W'(s1_row_reg);
        push_job.count      = cnt_after;
        push_job.frame_end  = s1_frame_end_reg;
    end

endmodule

### hw/rtl/glt_queue.sv
// short job queue between front and back
// depends on glt_pkg
module glt_queue import glt_pkg::*; (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  glt_job_t      push_job,
    input  logic          pop,
    output glt_job_t      head_job,
    output glt_q_status_t status
);

    glt_job_t           slots_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [Q_CNT_W-1:0] count_reg, count_next;
    logic               do_pop;

    // front never pushes into a full queue, it holds credit for that
    assign do_pop     = pop && (count_reg != '0);
    assign count_next = count_reg + Q_CNT_W'(push) - Q_CNT_W'(do_pop);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + Q_PTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + Q_PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slots_reg[wr_ptr_reg] <= push_job;
        end
    end

    assign head_job          = slots_reg[rd_ptr_reg];
    assign status.count      = count_reg;
    assign status.head_valid = count_reg != '0;

endmodule

### hw/rtl/glt_back.sv
// back end: splits each job into its result words and drives the output register
// depends on glt_pkg
module glt_back import glt_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  glt_job_t           head_job,
    input  glt_q_status_t      q_status,
    output logic               pop,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [PIX_W-1:0]   m_pixel_out,
    output logic [COORD_W-1:0] m_col,
    output logic [COORD_W-1:0] m_row_index,
    output logic               m_removed,
    output logic [COUNT_W-1:0] m_removed_total,
    output logic               m_frame_done
);

    glt_job_t         cur_reg;
    logic [RES_N-1:0] pend_reg;

    logic               m_valid_reg, m_valid_next;
    logic [PIX_W-1:0]   pix_reg, pix_next;
    logic [COORD_W-1:0] col_reg, col_next;
    logic [COORD_W-1:0] row_reg, row_next;
    logic               rem_reg, rem_next;
    logic [COUNT_W-1:0] total_reg;
    logic               done_reg, done_next;

    glt_job_t         src;
    logic [RES_N-1:0] src_mask, pick, remain;
    logic             out_free, emit;

    always_comb begin
        if (pend_reg != '0) begin
            src      = cur_reg;
            src_mask = pend_reg;
        end else begin
            src      = head_job;
            src_mask = q_status.head_valid ? head_job.present : '0;
        end
        pick     = src_mask & (~src_mask + RES_N'(1));   // lowest pending slot
        remain   = src_mask & ~pick;
        out_free = !m_valid_reg || m_ready;
        emit     = out_free && (src_mask != '0);
        pop      = emit && (pend_reg == '0);

        pix_next  = src.pix_new;
        col_next  = src.col;
        row_next  = src.row;
        rem_next  = 1'b0;
        if (pick[RES_CENTRE]) begin
            pix_next = src.pix_centre;
            col_next = src.col - COORD_W'(1);
            row_next = src.row - COORD_W'(1);
            rem_next = src.removed;
        end else if (pick[RES_RIGHT]) begin
            pix_next = src.pix_right;
            row_next = src.row - COORD_W'(1);
        end
        done_next = src.frame_end && (remain == '0);

        m_valid_next = emit ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (emit) begin
                pend_reg <= remain;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            cur_reg   <= src;
            pix_reg   <= pix_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
            rem_reg   <= rem_next;
            total_reg <= src.count;
            done_reg  <= done_next;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_pixel_out     = pix_reg;
    assign m_col           = col_reg;
    assign m_row_index     = row_reg;
    assign m_removed       = rem_reg;
    assign m_removed_total = total_reg;
    assign m_frame_done    = done_reg;

endmodule

### hw/rtl/golay_l_thinning_pass.sv
// one golay L hit-or-miss thinning pass over a raster pixel stream
// a pixel's first result word is registered in the stage after the read, a queue slot and the output register
// throughput: one pixel per cycle while the queue has room; the back end emits one word per cycle
// while m_ready allows, and a row averages one word per pixel, but last-row pixels after the first carry
// two words (the final one three), so the input slows below that rate over the last row of a frame
// reset: position, removal count, window and queue clear; line stores are not cleared
module golay_l_thinning_pass import glt_pkg::*; #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  cfg_idx_t           cfg_index,
    input  logic [CFG_W-1:0]   cfg_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [PIX_W-1:0]   s_pixel_in,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [PIX_W-1:0]   m_pixel_out,
    output logic [COORD_W-1:0] m_col,
    output logic [COORD_W-1:0] m_row_index,
    output logic               m_removed,
    output logic [COUNT_W-1:0] m_removed_total,
    output logic               m_frame_done
);

    logic [CFG_W-1:0]  image_width_reg;
    logic [CFG_W-1:0]  image_height_reg;
    logic [MASK_W-1:0] mask_select_reg;

    logic          push, pop;
    glt_job_t      push_job, head_job;
    glt_q_status_t q_status;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_width_reg  <= SIZE_RESET;
            image_height_reg <= SIZE_RESET;
            mask_select_reg  <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_IMAGE_WIDTH:  image_width_reg  <= cfg_wdata;
                CFG_IMAGE_HEIGHT: image_height_reg <= cfg_wdata;
                CFG_MASK_SELECT:  mask_select_reg  <= cfg_wdata[MASK_W-1:0];
                default: ;
            endcase
        end
    end

    glt_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_pixel_in   (s_pixel_in),
        .image_width  (image_width_reg),
        .image_height (image_height_reg),
        .mask_select  (mask_select_reg),
        .q_status     (q_status),
        .push         (push),
        .push_job     (push_job)
    );

    glt_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .status   (q_status)
    );

    glt_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .head_job        (head_job),
        .q_status        (q_status),
        .pop             (pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_pixel_out     (m_pixel_out),
        .m_col           (m_col),
        .m_row_index     (m_row_index),
        .m_removed       (m_removed),
        .m_removed_total (m_removed_total),
        .m_frame_done    (m_frame_done)
    );

endmodule
